### rtl/nir_pkg.sv
// Package: shared types, constants and helpers of the NEC IR frame decoder.
package nir_pkg;

    // Code FIFO (ring buffer, one slot kept free)
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);

    // Command queue between front and back
    localparam int CMD_QDEPTH = 8;
    localparam int CMD_IDX_W  = $clog2(CMD_QDEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_QDEPTH + 1);

    // Tolerance arithmetic: tol = (target * pct) / 100 via reciprocal
    localparam int TGT_W      = 16;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = TGT_W + PCT_W;
    localparam int RECIP_W    = 24;
    localparam int TOL_SHIFT  = 30;
    localparam int TOL_W      = 17;
    localparam int MUL_W      = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TOL_RECIP = 24'd10737419; // ceil(2^30 / 100)

    localparam int NUM_TGT    = 4;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [2:0] {
        REG_HEADER_US       = 3'd0,
        REG_REPEAT_US       = 3'd1,
        REG_ZERO_BIT_US     = 3'd2,
        REG_ONE_BIT_US      = 3'd3,
        REG_TOLERANCE_PCT   = 3'd4,
        REG_FRAME_BIT_TOTAL = 3'd5,
        REG_PIN_MASK        = 3'd6,
        REG_ENABLE          = 3'd7
    } nir_reg_idx_t;

    // Classified request handed from front to back
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_POP,
        CMD_HEADER,
        CMD_ZERO,
        CMD_ONE,
        CMD_ABORT
    } nir_cmd_t;

    typedef struct packed {
        logic [15:0] header_us;
        logic [15:0] repeat_us;
        logic [15:0] zero_bit_us;
        logic [15:0] one_bit_us;
        logic [6:0]  tolerance_pct;
        logic [5:0]  frame_bit_total;
        logic [15:0] pin_mask;
        logic        enable;
    } nir_cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] edge_pin;
        logic [31:0] edge_time;
    } nir_in_t;

    typedef struct packed {
        logic        code_valid;
        logic [31:0] popped_code;
        logic        frame_stored;
        logic        frame_lost;
    } nir_out_t;

    function automatic logic [FIFO_IDX_W-1:0] fifo_advance(input logic [FIFO_IDX_W-1:0] idx);
        logic [FIFO_IDX_W-1:0] res;
        if (idx == FIFO_IDX_W'(FIFO_DEPTH - 1))
            res = '0;
        else
            res = idx + FIFO_IDX_W'(1);
        return res;
    endfunction

endpackage

### rtl/nir_front.sv
// Front end: accepts requests, measures edge gaps and classifies them.
module nir_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nir_pkg::nir_cfg_t                 cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  nir_pkg::nir_in_t                  in_data,
    input  logic [nir_pkg::CMD_CNT_W-1:0]     q_count,
    output logic                              push,
    output nir_pkg::nir_cmd_t                 push_cmd
);

    localparam int NSTG = 3;
    localparam int LANE_HDR = 0;
    localparam int LANE_RPT = 1;
    localparam int LANE_ZERO = 2;
    localparam int LANE_ONE = 3;
    localparam int CMD_CNT_W_LOC = nir_pkg::CMD_CNT_W + 1;

    logic                          accept;
    logic [31:0]                   last_edge_reg, last_edge_next;
    logic                          primed_reg, primed_next;
    logic                          s0_meas;
    nir_pkg::nir_cmd_t             s0_cmd;
    logic [31:0]                   s0_gap;
    logic [CMD_CNT_W_LOC-1:0]      total;

    logic                          s_valid_reg [NSTG];
    logic                          s_meas_reg  [NSTG];
    nir_pkg::nir_cmd_t             s_cmd_reg   [NSTG];
    logic [31:0]                   s_gap_reg   [NSTG];

    logic [nir_pkg::TGT_W-1:0]     tgt      [nir_pkg::NUM_TGT];
    logic [nir_pkg::PROD_W-1:0]    prod_reg [nir_pkg::NUM_TGT];
    logic [nir_pkg::TOL_W-1:0]     tol_reg  [nir_pkg::NUM_TGT];
    logic                          hit      [nir_pkg::NUM_TGT];

    function automatic logic near_fn(input logic [31:0] gap,
                                     input logic [nir_pkg::TGT_W-1:0] target,
                                     input logic [nir_pkg::TOL_W-1:0] tol);
        logic [nir_pkg::TOL_W-1:0]   lo;
        logic [nir_pkg::TOL_W:0]     hi;
        // lower bound saturates at zero when tolerance exceeds 100 percent
        if (tol > nir_pkg::TOL_W'(target))
            lo = '0;
        else
            lo = nir_pkg::TOL_W'(target) - tol;
        hi = (nir_pkg::TOL_W + 1)'(target) + (nir_pkg::TOL_W + 1)'(tol);
        return (gap >= 32'(lo)) && (gap <= 32'(hi));
    endfunction

    // credit check: queue entries plus requests still in the pipe
    assign total = CMD_CNT_W_LOC'(q_count)
                 + CMD_CNT_W_LOC'(s_valid_reg[0])
                 + CMD_CNT_W_LOC'(s_valid_reg[1])
                 + CMD_CNT_W_LOC'(s_valid_reg[2]);
    assign in_ready = (total < CMD_CNT_W_LOC'(nir_pkg::CMD_QDEPTH));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s0_meas        = 1'b0;
        s0_cmd         = nir_pkg::CMD_NONE;
        last_edge_next = last_edge_reg;
        primed_next    = primed_reg;
        s0_gap         = in_data.edge_time - last_edge_reg;
        if (in_data.req_type == nir_pkg::REQ_POP)
        begin
            s0_cmd = nir_pkg::CMD_POP;
        end
        else if ((in_data.edge_pin == cfg.pin_mask) && cfg.enable)
        begin
            last_edge_next = in_data.edge_time;
            if (primed_reg)
                s0_meas = 1'b1;
            else
                primed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            primed_reg    <= 1'b0;
            for (int i = 0; i < NSTG; i++)
                s_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_edge_reg <= last_edge_next;
                primed_reg    <= primed_next;
            end
            s_valid_reg[0] <= accept;
            for (int i = 1; i < NSTG; i++)
                s_valid_reg[i] <= s_valid_reg[i-1];
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        s_meas_reg[0] <= s0_meas;
        s_cmd_reg[0]  <= s0_cmd;
        s_gap_reg[0]  <= s0_gap;
        for (int i = 1; i < NSTG; i++)
        begin
            s_meas_reg[i] <= s_meas_reg[i-1];
            s_cmd_reg[i]  <= s_cmd_reg[i-1];
            s_gap_reg[i]  <= s_gap_reg[i-1];
        end
    end

    // tolerance lanes track configuration through the product and tolerance registers
    always_comb
    begin
        tgt[LANE_HDR]  = cfg.header_us;
        tgt[LANE_RPT]  = cfg.repeat_us;
        tgt[LANE_ZERO] = cfg.zero_bit_us;
        tgt[LANE_ONE]  = cfg.one_bit_us;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < nir_pkg::NUM_TGT; i++)
        begin
            prod_reg[i] <= nir_pkg::PROD_W'(tgt[i]) * nir_pkg::PROD_W'(cfg.tolerance_pct);
            tol_reg[i]  <= nir_pkg::TOL_W'((nir_pkg::MUL_W'(prod_reg[i])
                           * nir_pkg::MUL_W'(nir_pkg::TOL_RECIP)) >> nir_pkg::TOL_SHIFT);
        end
    end

    always_comb
    begin
        for (int i = 0; i < nir_pkg::NUM_TGT; i++)
            hit[i] = near_fn(s_gap_reg[NSTG-1], tgt[i], tol_reg[i]);
    end

    // header first, then repeat, then bit tests
    always_comb
    begin
        push     = s_valid_reg[NSTG-1];
        push_cmd = s_cmd_reg[NSTG-1];
        if (s_meas_reg[NSTG-1])
        begin
            if (hit[LANE_HDR])
                push_cmd = nir_pkg::CMD_HEADER;
            else if (hit[LANE_RPT])
                push_cmd = nir_pkg::CMD_NONE;
            else if (hit[LANE_ZERO])
                push_cmd = nir_pkg::CMD_ZERO;
            else if (hit[LANE_ONE])
                push_cmd = nir_pkg::CMD_ONE;
            else
                push_cmd = nir_pkg::CMD_ABORT;
        end
    end

endmodule

### rtl/nir_cmd_queue.sv
// Command queue: small FIFO of classified requests between front and back.
module nir_cmd_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  nir_pkg::nir_cmd_t              push_cmd,
    input  logic                           pop,
    output logic                           head_valid,
    output nir_pkg::nir_cmd_t              head_cmd,
    output logic [nir_pkg::CMD_CNT_W-1:0]  count
);

    nir_pkg::nir_cmd_t                 mem_reg [nir_pkg::CMD_QDEPTH];
    logic [nir_pkg::CMD_IDX_W-1:0]     wr_ptr_reg;
    logic [nir_pkg::CMD_IDX_W-1:0]     rd_ptr_reg;
    logic [nir_pkg::CMD_CNT_W-1:0]     count_reg;
    logic                              do_pop;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + nir_pkg::CMD_IDX_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + nir_pkg::CMD_IDX_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + nir_pkg::CMD_CNT_W'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - nir_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### rtl/nir_back.sv
// Back end: frame assembly, code FIFO and result register.
module nir_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [5:0]         frame_bit_total,
    input  logic               head_valid,
    input  nir_pkg::nir_cmd_t  head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output nir_pkg::nir_out_t  out_data
);

    logic [31:0]                      code_store [nir_pkg::FIFO_DEPTH];
    logic [nir_pkg::FIFO_IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [nir_pkg::FIFO_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [nir_pkg::FIFO_IDX_W-1:0]   wr_adv;
    logic                             receiving_reg, receiving_next;
    logic [31:0]                      shift_reg, shift_next;
    logic [5:0]                       bits_reg, bits_next;
    logic                             store_en;
    logic                             out_valid_reg;
    nir_pkg::nir_out_t                out_data_reg, out_data_next;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign wr_adv    = nir_pkg::fifo_advance(wr_idx_reg);

    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        receiving_next = receiving_reg;
        shift_next     = shift_reg;
        bits_next      = bits_reg;
        store_en       = 1'b0;
        out_data_next  = '0;
        case (head_cmd)
            nir_pkg::CMD_POP:
            begin
                if (wr_idx_reg != rd_idx_reg)
                begin
                    out_data_next.code_valid  = 1'b1;
                    out_data_next.popped_code = code_store[rd_idx_reg];
                    rd_idx_next = nir_pkg::fifo_advance(rd_idx_reg);
                end
            end
            nir_pkg::CMD_HEADER:
            begin
                receiving_next = 1'b1;
                bits_next      = '0;
                shift_next     = '0;
            end
            nir_pkg::CMD_ZERO, nir_pkg::CMD_ONE:
            begin
                if (receiving_reg)
                begin
                    shift_next = {shift_reg[30:0], (head_cmd == nir_pkg::CMD_ONE)};
                    bits_next  = bits_reg + 6'd1;
                    if (bits_next >= frame_bit_total)
                    begin
                        if (wr_adv != rd_idx_reg)
                        begin
                            store_en    = 1'b1;
                            wr_idx_next = wr_adv;
                            out_data_next.frame_stored = 1'b1;
                        end
                        else
                        begin
                            out_data_next.frame_lost = 1'b1;
                        end
                        receiving_next = 1'b0;
                    end
                end
            end
            nir_pkg::CMD_ABORT:
            begin
                if (receiving_reg)
                begin
                    receiving_next = 1'b0;
                    bits_next      = '0;
                    shift_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            receiving_reg <= 1'b0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                wr_idx_reg    <= wr_idx_next;
                rd_idx_reg    <= rd_idx_next;
                receiving_reg <= receiving_next;
                shift_reg     <= shift_next;
                bits_reg      <= bits_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= out_data_next;
        if (pop && store_en)
            code_store[wr_idx_reg] <= shift_next;
    end

endmodule

### rtl/nec_ir_frame_decoder.sv
// Top level: NEC IR frame decoder with configuration registers and code FIFO.
//
// Each request is either a falling-edge timestamp (req_type 0) or a pop of one
// decoded code (req_type 1), and each request yields exactly one result, in
// order. Edges on pin_mask while enable is set are timed against the previous
// such edge (modulo 2^32); the first one after reset only records its time.
// Gaps near header_us start a frame, gaps near repeat_us are ignored, and
// during a frame gaps near zero_bit_us / one_bit_us shift in bits MSB first;
// any other gap aborts. A finished frame goes into an 8-entry ring FIFO that
// keeps one slot free (frame_lost when full). Throughput is one request per
// clock while in_ready is high. From acceptance, a request passes three front
// stages (gap subtract, then two stages that let the tolerance multipliers
// track configuration; the window compares sit after the last one), the
// compares push into the command queue, and the back end loads the result
// register when it pops the queue head; the pop waits while a pending result
// is not taken. in_ready drops only when the 8-entry command queue plus
// requests in the front pipeline would overflow, i.e. when results back up.
// Tolerance windows follow a configuration write through the product and tolerance registers.
module nec_ir_frame_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nir_pkg::nir_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output nir_pkg::nir_out_t   out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    nir_pkg::nir_cfg_t                  cfg_reg;
    logic                               push;
    nir_pkg::nir_cmd_t                  push_cmd;
    logic                               q_pop;
    logic                               q_head_valid;
    nir_pkg::nir_cmd_t                  q_head_cmd;
    logic [nir_pkg::CMD_CNT_W-1:0]      q_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_us       <= 16'd13500;
            cfg_reg.repeat_us       <= 16'd11250;
            cfg_reg.zero_bit_us     <= 16'd1125;
            cfg_reg.one_bit_us      <= 16'd2250;
            cfg_reg.tolerance_pct   <= 7'd20;
            cfg_reg.frame_bit_total <= 6'd32;
            cfg_reg.pin_mask        <= 16'd32;
            cfg_reg.enable          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (nir_pkg::nir_reg_idx_t'(cfg_index))
                nir_pkg::REG_HEADER_US:       cfg_reg.header_us       <= cfg_data;
                nir_pkg::REG_REPEAT_US:       cfg_reg.repeat_us       <= cfg_data;
                nir_pkg::REG_ZERO_BIT_US:     cfg_reg.zero_bit_us     <= cfg_data;
                nir_pkg::REG_ONE_BIT_US:      cfg_reg.one_bit_us      <= cfg_data;
                nir_pkg::REG_TOLERANCE_PCT:   cfg_reg.tolerance_pct   <= cfg_data[6:0];
                nir_pkg::REG_FRAME_BIT_TOTAL: cfg_reg.frame_bit_total <= cfg_data[5:0];
                nir_pkg::REG_PIN_MASK:        cfg_reg.pin_mask        <= cfg_data;
                nir_pkg::REG_ENABLE:          cfg_reg.enable          <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // front: timing and classification
    nir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_count  (q_count),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples front from result backpressure
    nir_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .count      (q_count)
    );

    // back: frame assembly, code FIFO, result register
    nir_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_bit_total (cfg_reg.frame_bit_total),
        .head_valid      (q_head_valid),
        .head_cmd        (q_head_cmd),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

endmodule
